FILE: rtl/vsc_pkg.sv
`timescale 1ns / 1ps

package vsc_pkg;

    // Fixed field widths
    localparam int COORD_W = 16;
    localparam int SIDX_W  = 5;
    localparam int CFG_W   = 16;

    // Configuration register indexes
    localparam logic CFG_VIEW_WIDTH  = 1'b0;
    localparam logic CFG_VIEW_HEIGHT = 1'b1;

    localparam logic [COORD_W-1:0] VIEW_WIDTH_RST  = 16'd80;
    localparam logic [COORD_W-1:0] VIEW_HEIGHT_RST = 16'd24;

    typedef enum logic [2:0] {
        ACT_APPEND = 3'd0,
        ACT_CLEAR  = 3'd1,
        ACT_ROWS   = 3'd2,
        ACT_COLS   = 3'd3,
        ACT_HIT    = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        KIND_REDRAW  = 2'd0,
        KIND_SUMMARY = 2'd1,
        KIND_HIT     = 2'd2
    } t_kind;

    // What the per-entry test checks against the window
    typedef enum logic [1:0] {
        MODE_ROWS,
        MODE_VIEW,
        MODE_POINT
    } t_test_mode;

    typedef struct packed {
        logic [2:0]         action;
        logic [COORD_W-1:0] shape_x;
        logic [COORD_W-1:0] shape_y;
        logic [COORD_W-1:0] shape_w;
        logic [COORD_W-1:0] shape_h;
        logic [COORD_W-1:0] amount;
        logic               direction;
        logic [COORD_W-1:0] point_col;
        logic [COORD_W-1:0] point_row;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SIDX_W-1:0]  shape_index;
        logic               found;
        logic [COORD_W-1:0] view_x;
        logic [COORD_W-1:0] view_y;
        logic [COORD_W-1:0] scrolled_by;
        logic               clear_screen;
        logic               table_full;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
    } t_rect;

    // Test window: half-open bands, or a point in x_lo / y_lo
    typedef struct packed {
        t_test_mode         mode;
        logic [COORD_W-1:0] x_lo;
        logic [COORD_W-1:0] x_hi;
        logic [COORD_W-1:0] y_lo;
        logic [COORD_W-1:0] y_hi;
    } t_window;

endpackage

FILE: rtl/vsc_rect_mem.sv
`timescale 1ns / 1ps

module vsc_rect_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic [AW-1:0]  i_waddr,
    input  vsc_pkg::t_rect i_wdata,
    input  logic [AW-1:0]  i_raddr,
    output vsc_pkg::t_rect o_rdata
);

    vsc_pkg::t_rect r_mem [DEPTH];
    vsc_pkg::t_rect r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/vsc_rect_test.sv
`timescale 1ns / 1ps

module vsc_rect_test (
    input  vsc_pkg::t_rect   i_rect,
    input  vsc_pkg::t_window i_win,
    output logic             o_match
);

    logic [vsc_pkg::COORD_W-1:0] right;
    logic [vsc_pkg::COORD_W-1:0] bottom;
    logic                        rows_hit;
    logic                        cols_hit;
    logic                        point_hit;

    // Edges wrap at 16 bits
    assign right  = i_rect.left + i_rect.width;
    assign bottom = i_rect.top + i_rect.height;

    assign rows_hit  = (i_rect.top < i_win.y_hi) && (bottom > i_win.y_lo);
    assign cols_hit  = (i_rect.left < i_win.x_hi) && (right > i_win.x_lo);
    assign point_hit = (i_win.x_lo >= i_rect.left) && (i_win.x_lo < right) &&
                       (i_win.y_lo >= i_rect.top) && (i_win.y_lo < bottom);

    always_comb begin
        case (i_win.mode)
            vsc_pkg::MODE_ROWS:  o_match = rows_hit;
            vsc_pkg::MODE_VIEW:  o_match = rows_hit && cols_hit;
            vsc_pkg::MODE_POINT: o_match = point_hit;
            default:             o_match = 1'b0;
        endcase
    end

endmodule

FILE: rtl/viewport_scroll_culling.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+---------------------------
// in       | in  | i_in_valid / o_in_stall | i_in_item  (t_in_item)
// out      | out | o_out_valid / i_out_stall | o_out_item (t_out_item)
// cfg      | in  | i_cfg_we               | i_cfg_index, i_cfg_data
//
// One item at a time. Append, clear, unused codes and commands that change
// nothing go from accept straight to the summary. A scroll or hit test walks
// the table at one entry a cycle, except while a stalled output holds a
// match, from the single read port of the rectangle memory.
// Reset (i_rst_n low, synchronous) empties the table, zeroes the origin and
// restores view size 80 x 24; the rectangle memory itself is not cleared.
// A stalled output holds the walk on a matching entry; the output register
// lets a new item transfer while the last result still waits.

module viewport_scroll_culling #(
    parameter int MAX_SHAPES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [vsc_pkg::CFG_W-1:0] i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  vsc_pkg::t_in_item  i_in_item,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output vsc_pkg::t_out_item o_out_item
);

    localparam int IW = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
    localparam int CW = $clog2(MAX_SHAPES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SUM
    } t_state;

    t_state r_state;

    // configuration
    logic [vsc_pkg::COORD_W-1:0] r_view_w;
    logic [vsc_pkg::COORD_W-1:0] r_view_h;

    // table bookkeeping and viewport
    logic [CW-1:0]               r_count;
    logic [vsc_pkg::COORD_W-1:0] r_origin_x;
    logic [vsc_pkg::COORD_W-1:0] r_origin_y;

    // per-command context
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_last_idx;
    vsc_pkg::t_window   r_win;
    vsc_pkg::t_out_item r_sum;   // summary template, view fields filled late

    // output register
    logic               r_out_valid;
    vsc_pkg::t_out_item r_out;

    // next values decided in the transfer cycle
    logic [vsc_pkg::COORD_W-1:0] n_origin_x;
    logic [vsc_pkg::COORD_W-1:0] n_origin_y;
    vsc_pkg::t_window            n_win;
    vsc_pkg::t_out_item          n_sum;
    logic                        n_scan;
    logic [CW-1:0]               n_count;

    logic in_xfer;
    logic out_free;
    logic out_load;
    logic table_full;
    logic append_we;
    logic [CW-1:0] count_m1;

    logic [vsc_pkg::COORD_W-1:0] amt;
    logic [vsc_pkg::COORD_W-1:0] clamp_y;
    logic [vsc_pkg::COORD_W-1:0] clamp_x;
    logic [vsc_pkg::COORD_W-1:0] band_lo;

    vsc_pkg::t_rect rd_rect;
    vsc_pkg::t_rect wr_rect;
    logic [IW-1:0]  rd_addr;
    logic           match;
    logic           at_last;
    logic           advance;
    logic           is_point;

    vsc_pkg::t_out_item redraw_item;
    vsc_pkg::t_out_item hit_item;
    vsc_pkg::t_out_item sum_item;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // a result enters the output register this cycle
    assign out_load = out_free && (((r_state == S_SCAN) && match) || (r_state == S_SUM));

    assign table_full = (r_count >= CW'(MAX_SHAPES));
    assign append_we  = in_xfer && (i_in_item.action == vsc_pkg::ACT_APPEND) && !table_full;
    assign count_m1   = r_count - CW'(1);

    assign wr_rect.left   = i_in_item.shape_x;
    assign wr_rect.top    = i_in_item.shape_y;
    assign wr_rect.width  = i_in_item.shape_w;
    assign wr_rect.height = i_in_item.shape_h;

    // ---------------------------------------------------------------
    // Command decode in the transfer cycle: new origin, test window and
    // the summary that will close the command.
    // ---------------------------------------------------------------
    assign amt     = i_in_item.amount;
    assign clamp_y = (amt > r_origin_y) ? r_origin_y : amt;
    assign clamp_x = (amt > r_origin_x) ? r_origin_x : amt;
    assign band_lo = r_origin_y + r_view_h;

    always_comb begin
        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_win      = '0;
        n_win.mode = vsc_pkg::MODE_ROWS;
        n_scan     = 1'b0;
        n_count    = r_count;
        n_sum      = '0;
        n_sum.kind = vsc_pkg::KIND_SUMMARY;
        n_sum.last = 1'b1;

        case (i_in_item.action)
            vsc_pkg::ACT_APPEND: begin
                if (!table_full) begin
                    n_sum.shape_index = vsc_pkg::SIDX_W'(r_count);
                    n_count           = r_count + CW'(1);
                end else begin
                    n_sum.table_full = 1'b1;
                end
            end
            vsc_pkg::ACT_CLEAR: begin
                n_count = '0;
            end
            vsc_pkg::ACT_ROWS: begin
                if (amt != '0 && r_count != '0) begin
                    if (i_in_item.direction) begin
                        // scrolling up exposes rows below the old view
                        n_win.y_lo        = band_lo;
                        n_win.y_hi        = band_lo + amt;
                        n_origin_y        = r_origin_y + amt;
                        n_sum.scrolled_by = amt;
                        n_scan            = 1'b1;
                    end else if (clamp_y != '0) begin
                        // scrolling down exposes rows above the old view
                        n_win.y_lo        = r_origin_y - clamp_y;
                        n_win.y_hi        = r_origin_y;
                        n_origin_y        = r_origin_y - clamp_y;
                        n_sum.scrolled_by = clamp_y;
                        n_scan            = 1'b1;
                    end
                end
            end
            vsc_pkg::ACT_COLS: begin
                if (r_count != '0) begin
                    if (i_in_item.direction) begin
                        n_origin_x        = r_origin_x + amt;
                        n_sum.scrolled_by = amt;
                    end else begin
                        n_origin_x        = r_origin_x - clamp_x;
                        n_sum.scrolled_by = clamp_x;
                    end
                    // screen is cleared: redraw everything in the new view
                    n_win.mode         = vsc_pkg::MODE_VIEW;
                    n_win.x_lo         = n_origin_x;
                    n_win.x_hi         = n_origin_x + r_view_w;
                    n_win.y_lo         = r_origin_y;
                    n_win.y_hi         = band_lo;
                    n_sum.clear_screen = 1'b1;
                    n_scan             = 1'b1;
                end
            end
            vsc_pkg::ACT_HIT: begin
                // point goes from view space to book space
                n_sum.kind = vsc_pkg::KIND_HIT;
                n_win.mode = vsc_pkg::MODE_POINT;
                n_win.x_lo = r_origin_x + i_in_item.point_col;
                n_win.y_lo = r_origin_y + i_in_item.point_row;
                n_scan     = (r_count != '0);
            end
            default: begin
                // unused codes: plain summary
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Table walk. rd_rect holds entry r_idx; the address for the next
    // cycle moves on only when this entry needs no output or the output
    // register can take it.
    // ---------------------------------------------------------------
    assign is_point = (r_win.mode == vsc_pkg::MODE_POINT);
    assign at_last  = (r_idx == r_last_idx);
    assign advance  = !match || out_free;

    always_comb begin
        if (r_state == S_SCAN && advance && !at_last) begin
            rd_addr = r_idx + IW'(1);
        end else if (r_state == S_SCAN) begin
            rd_addr = r_idx;
        end else begin
            rd_addr = '0;   // first entry is ready when the walk starts
        end
    end

    always_comb begin
        redraw_item             = r_sum;
        redraw_item.kind        = vsc_pkg::KIND_REDRAW;
        redraw_item.shape_index = vsc_pkg::SIDX_W'(r_idx);
        redraw_item.view_x      = r_origin_x;
        redraw_item.view_y      = r_origin_y;
        redraw_item.last        = 1'b0;

        hit_item             = r_sum;
        hit_item.shape_index = vsc_pkg::SIDX_W'(r_idx);
        hit_item.found       = 1'b1;
        hit_item.view_x      = r_origin_x;
        hit_item.view_y      = r_origin_y;

        sum_item        = r_sum;
        sum_item.view_x = r_origin_x;
        sum_item.view_y = r_origin_y;
    end

    vsc_rect_mem #(
        .DEPTH (MAX_SHAPES),
        .AW    (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (append_we),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata (wr_rect),
        .i_raddr (rd_addr),
        .o_rdata (rd_rect)
    );

    vsc_rect_test u_test (
        .i_rect  (rd_rect),
        .i_win   (r_win),
        .o_match (match)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_w <= vsc_pkg::VIEW_WIDTH_RST;
            r_view_h <= vsc_pkg::VIEW_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vsc_pkg::CFG_VIEW_WIDTH:  r_view_w <= i_cfg_data;
                vsc_pkg::CFG_VIEW_HEIGHT: r_view_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-command context, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_win      <= n_win;
            r_sum      <= n_sum;
            r_last_idx <= count_m1[IW-1:0];
        end
    end

    // control state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_count    <= n_count;
                        r_origin_x <= n_origin_x;
                        r_origin_y <= n_origin_y;
                        r_idx      <= '0;
                        r_state    <= n_scan ? S_SCAN : S_SUM;
                    end
                end
                S_SCAN: begin
                    if (match && out_free) begin
                        r_out <= is_point ? hit_item : redraw_item;
                    end
                    if (match && out_free && is_point) begin
                        r_state <= S_IDLE;          // first hit ends the test
                    end else if (advance) begin
                        if (at_last) begin
                            r_state <= S_SUM;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                    end
                end
                S_SUM: begin
                    if (out_free) begin
                        r_out   <= sum_item;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: bench/viewport_scroll_culling_tb.sv
`timescale 1ns / 1ps

module viewport_scroll_culling_tb;

    localparam int NSHAPES      = 32;
    localparam int CYCLE_LIMIT  = 400000;
    // a full table walk plus the summary, with margin
    localparam int DRAIN_CYCLES = 40;

    // action codes the block has no use for
    localparam logic [2:0] ACT_SPARE_LO  = 3'd5;
    localparam logic [2:0] ACT_SPARE_MID = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI  = 3'd7;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic                      i_cfg_index;
    logic [vsc_pkg::CFG_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    vsc_pkg::t_in_item         i_in_item;
    logic                      o_out_valid;
    logic                      i_out_stall;
    vsc_pkg::t_out_item        o_out_item;

    viewport_scroll_culling u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // One directed row. When typed is set, the single result is given here:
    // origin still at zero, nothing scrolled, last set.
    typedef struct packed {
        vsc_pkg::t_in_item          item;
        logic                       typed;
        logic [1:0]                 kind;
        logic [vsc_pkg::SIDX_W-1:0] idx;
        logic                       fnd;
    } t_dir_row;

    // Scene model: rectangle table, origin and view size
    vsc_pkg::t_rect              shape_tab [NSHAPES];
    logic [5:0]                  shape_cnt;
    logic [vsc_pkg::COORD_W-1:0] org_x;
    logic [vsc_pkg::COORD_W-1:0] org_y;
    logic [vsc_pkg::COORD_W-1:0] view_w;
    logic [vsc_pkg::COORD_W-1:0] view_h;

    // Results still owed by the block, oldest first
    vsc_pkg::t_out_item owed_results [$];

    int errors;
    int cycles;
    int items_sent;
    int results_seen;
    int redraws_owed;
    int hits_owed;
    int drops_owed;
    int idle_pct;
    int stall_pct;

    //--------------------------------------------------------------------
    // Clock, cycle limit
    //--------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, owed_results.size());
            $display("viewport_scroll_culling: mismatch");
            $finish;
        end
    end

    //--------------------------------------------------------------------
    // Scene model
    //--------------------------------------------------------------------
    function automatic logic [vsc_pkg::COORD_W-1:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[vsc_pkg::COORD_W-1:0];
    endfunction

    // Result stamped with the origin as it stands now
    function automatic vsc_pkg::t_out_item make_result(
        input vsc_pkg::t_kind k, input logic [vsc_pkg::SIDX_W-1:0] idx,
        input logic fnd, input logic [vsc_pkg::COORD_W-1:0] moved,
        input logic clr, input logic full, input logic fin);
        vsc_pkg::t_out_item r;
        r.kind         = k;
        r.shape_index  = idx;
        r.found        = fnd;
        r.view_x       = org_x;
        r.view_y       = org_y;
        r.scrolled_by  = moved;
        r.clear_screen = clr;
        r.table_full   = full;
        r.last         = fin;
        return r;
    endfunction

    // Apply one transfer to the scene and queue the results it owes
    task automatic apply_command(input vsc_pkg::t_in_item it);
        logic [vsc_pkg::COORD_W-1:0] amt;
        logic [vsc_pkg::COORD_W-1:0] lo;
        logic [vsc_pkg::COORD_W-1:0] hi;
        logic [vsc_pkg::COORD_W-1:0] bx;
        logic [vsc_pkg::COORD_W-1:0] by;
        logic [vsc_pkg::COORD_W-1:0] vx1;
        logic [vsc_pkg::COORD_W-1:0] vy1;
        logic [vsc_pkg::COORD_W-1:0] x1;
        logic [vsc_pkg::COORD_W-1:0] y1;
        bit                          hit_done;
        int                          i;

        amt = it.amount;
        case (it.action)
            vsc_pkg::ACT_APPEND: begin
                if (shape_cnt < NSHAPES) begin
                    shape_tab[shape_cnt] = {it.shape_x, it.shape_y, it.shape_w, it.shape_h};
                    owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                       shape_cnt[vsc_pkg::SIDX_W-1:0],
                                                       0, 0, 0, 0, 1));
                    shape_cnt = shape_cnt + 1;
                end else begin
                    // table full: rectangle dropped
                    owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                       0, 0, 0, 0, 1, 1));
                    drops_owed++;
                end
            end
            vsc_pkg::ACT_CLEAR: begin
                shape_cnt = 0;
                owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY, 0, 0, 0, 0, 0, 1));
            end
            vsc_pkg::ACT_ROWS: begin
                if (amt == 0 || shape_cnt == 0) begin
                    owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                       0, 0, 0, 0, 0, 1));
                end else begin
                    if (it.direction) begin
                        lo    = org_y + view_h;
                        hi    = lo + amt;
                        org_y = org_y + amt;
                    end else begin
                        if (amt > org_y) amt = org_y;
                        lo    = org_y - amt;
                        hi    = org_y;
                        org_y = lo;
                    end
                    if (amt == 0) begin
                        // downward scroll clamped away entirely
                        owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                           0, 0, 0, 0, 0, 1));
                    end else begin
                        // redraw everything touching the newly exposed band [lo, hi)
                        for (i = 0; i < shape_cnt; i++) begin
                            y1 = shape_tab[i].top + shape_tab[i].height;
                            if (shape_tab[i].top < hi && y1 > lo) begin
                                owed_results.push_back(make_result(vsc_pkg::KIND_REDRAW,
                                    i[vsc_pkg::SIDX_W-1:0], 0, amt, 0, 0, 0));
                                redraws_owed++;
                            end
                        end
                        owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                           0, 0, amt, 0, 0, 1));
                    end
                end
            end
            vsc_pkg::ACT_COLS: begin
                if (shape_cnt == 0) begin
                    owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                       0, 0, 0, 0, 0, 1));
                end else begin
                    if (it.direction) begin
                        org_x = org_x + amt;
                    end else begin
                        if (amt > org_x) amt = org_x;
                        org_x = org_x - amt;
                    end
                    // screen is cleared, so every visible rectangle is redrawn
                    vx1 = org_x + view_w;
                    vy1 = org_y + view_h;
                    for (i = 0; i < shape_cnt; i++) begin
                        x1 = shape_tab[i].left + shape_tab[i].width;
                        y1 = shape_tab[i].top + shape_tab[i].height;
                        if (shape_tab[i].top < vy1 && y1 > org_y &&
                            shape_tab[i].left < vx1 && x1 > org_x) begin
                            owed_results.push_back(make_result(vsc_pkg::KIND_REDRAW,
                                i[vsc_pkg::SIDX_W-1:0], 0, amt, 1, 0, 0));
                            redraws_owed++;
                        end
                    end
                    owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY,
                                                       0, 0, amt, 1, 0, 1));
                end
            end
            vsc_pkg::ACT_HIT: begin
                bx       = org_x + it.point_col;
                by       = org_y + it.point_row;
                hit_done = 0;
                for (i = 0; i < shape_cnt && !hit_done; i++) begin
                    x1 = shape_tab[i].left + shape_tab[i].width;
                    y1 = shape_tab[i].top + shape_tab[i].height;
                    if (bx >= shape_tab[i].left && bx < x1 &&
                        by >= shape_tab[i].top && by < y1) begin
                        owed_results.push_back(make_result(vsc_pkg::KIND_HIT,
                                                           i[vsc_pkg::SIDX_W-1:0],
                                                           1, 0, 0, 0, 1));
                        hit_done = 1;
                        hits_owed++;
                    end
                end
                if (!hit_done)
                    owed_results.push_back(make_result(vsc_pkg::KIND_HIT, 0, 0, 0, 0, 0, 1));
            end
            default: begin
                owed_results.push_back(make_result(vsc_pkg::KIND_SUMMARY, 0, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    //--------------------------------------------------------------------
    // Stimulus helpers
    //--------------------------------------------------------------------
    function automatic t_dir_row stim_row(input logic [2:0] act,
                                          input logic [vsc_pkg::COORD_W-1:0] x, y, w, h, amt,
                                          input logic dirn,
                                          input logic [vsc_pkg::COORD_W-1:0] pc, pr,
                                          input logic typed, input logic [1:0] k,
                                          input logic [vsc_pkg::SIDX_W-1:0] idx,
                                          input logic fnd);
        t_dir_row r;
        r.item.action    = act;
        r.item.shape_x   = x;
        r.item.shape_y   = y;
        r.item.shape_w   = w;
        r.item.shape_h   = h;
        r.item.amount    = amt;
        r.item.direction = dirn;
        r.item.point_col = pc;
        r.item.point_row = pr;
        r.typed          = typed;
        r.kind           = k;
        r.idx            = idx;
        r.fnd            = fnd;
        return r;
    endfunction

    // Unused fields stay random over their full range so every bit toggles.
    // Geometry is mostly kept near the view so scrolls and hits find things.
    function automatic vsc_pkg::t_in_item random_item(input bit append_only);
        vsc_pkg::t_in_item           it;
        int unsigned                 pick;
        int unsigned                 j;
        logic [vsc_pkg::COORD_W-1:0] span;
        logic [vsc_pkg::COORD_W-1:0] amt;

        it.action    = vsc_pkg::ACT_APPEND;
        it.shape_x   = rand16();
        it.shape_y   = rand16();
        it.shape_w   = rand16();
        it.shape_h   = rand16();
        it.amount    = rand16();
        it.direction = ($urandom_range(1) == 1);
        it.point_col = rand16();
        it.point_row = rand16();

        j    = $urandom_range(9);
        amt  = (j == 0) ? 16'd0 : (j < 3) ? rand16() : rand16() % 16'd40;
        pick = append_only ? 0 : $urandom_range(99);

        if (pick < 35) begin
            it.action = vsc_pkg::ACT_APPEND;
            if ($urandom_range(3) != 0) begin
                it.shape_x = org_x + (rand16() % 16'd160) - 16'd40;
                it.shape_y = org_y + (rand16() % 16'd80) - 16'd20;
                it.shape_w = rand16() % 16'd60;
                it.shape_h = rand16() % 16'd30;
            end
        end else if (pick < 39) begin
            it.action = vsc_pkg::ACT_CLEAR;
        end else if (pick < 59) begin
            it.action = vsc_pkg::ACT_ROWS;
            it.amount = amt;
        end else if (pick < 74) begin
            it.action = vsc_pkg::ACT_COLS;
            it.amount = amt;
        end else if (pick < 95) begin
            it.action = vsc_pkg::ACT_HIT;
            if (shape_cnt != 0 && $urandom_range(2) != 0) begin
                // aim inside a stored rectangle
                j    = $urandom_range(shape_cnt - 1);
                span = shape_tab[j].width;
                it.point_col = shape_tab[j].left - org_x +
                               ((span == 0) ? 16'd0 : rand16() % span);
                span = shape_tab[j].height;
                it.point_row = shape_tab[j].top - org_y +
                               ((span == 0) ? 16'd0 : rand16() % span);
            end else if ($urandom_range(1) == 1) begin
                it.point_col = rand16() % 16'd100;
                it.point_row = rand16() % 16'd40;
            end
        end else begin
            case ($urandom_range(2))
                0:       it.action = ACT_SPARE_LO;
                1:       it.action = ACT_SPARE_MID;
                default: it.action = ACT_SPARE_HI;
            endcase
        end
        return it;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    // A typed result replaces the scene model's for that transfer.
    task automatic send_item(input vsc_pkg::t_in_item it, input bit typed,
                             input vsc_pkg::t_out_item typed_res);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        apply_command(it);
        if (typed) begin
            void'(owed_results.pop_back());
            owed_results.push_back(typed_res);
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait until every owed result has come, let the block settle
    task automatic drain();
        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Both registers, back to back, block idle
    task automatic set_view(input logic [vsc_pkg::CFG_W-1:0] w,
                            input logic [vsc_pkg::CFG_W-1:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= vsc_pkg::CFG_VIEW_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        view_w = w;
        @(negedge i_clk);
        i_cfg_index <= vsc_pkg::CFG_VIEW_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        view_h = h;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [vsc_pkg::COORD_W-1:0] want,
                               input logic [vsc_pkg::COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    //--------------------------------------------------------------------
    // Receiver: random stall, check each transfer against the oldest owed
    //--------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_out
        vsc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $error("result with nothing owed: %h", o_out_item);
                errors++;
            end else begin
                want = owed_results.pop_front();
                check_field("kind",         want.kind,         o_out_item.kind);
                check_field("shape_index",  want.shape_index,  o_out_item.shape_index);
                check_field("found",        want.found,        o_out_item.found);
                check_field("view_x",       want.view_x,       o_out_item.view_x);
                check_field("view_y",       want.view_y,       o_out_item.view_y);
                check_field("scrolled_by",  want.scrolled_by,  o_out_item.scrolled_by);
                check_field("clear_screen", want.clear_screen, o_out_item.clear_screen);
                check_field("table_full",   want.table_full,   o_out_item.table_full);
                check_field("last",         want.last,         o_out_item.last);
                results_seen++;
            end
        end
    end

    //--------------------------------------------------------------------
    // Main sequence
    //--------------------------------------------------------------------
    initial begin : main_seq
        t_dir_row           dir_tab [$];
        vsc_pkg::t_out_item typed_res;
        int                 ph;
        int                 n;
        int                 burst;

        // everything known from time zero
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = vsc_pkg::CFG_VIEW_WIDTH;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_item   = '0;
        i_out_stall = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;

        shape_cnt = 0;
        org_x     = 0;
        org_y     = 0;
        view_w    = vsc_pkg::VIEW_WIDTH_RST;
        view_h    = vsc_pkg::VIEW_HEIGHT_RST;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows, run with the reset view of 80 x 24.
        // Empty table: hit misses, scrolls and spare codes only summarize.
        dir_tab.push_back(stim_row(vsc_pkg::ACT_HIT, 0, 0, 0, 0, 0, 0, 0, 0,
                                   1, vsc_pkg::KIND_HIT, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 5, 1, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_COLS, 0, 0, 0, 0, 5, 1, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(ACT_SPARE_LO, 0, 0, 0, 0, 0, 0, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(ACT_SPARE_HI, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 1, 16'hFFFF, 16'hFFFF,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        // appends report their slot
        dir_tab.push_back(stim_row(vsc_pkg::ACT_APPEND, 0, 0, 10, 5, 0, 0, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 0, 0, 0, 0, 1, vsc_pkg::KIND_SUMMARY, 1, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_APPEND, 70, 20, 20, 10, 0, 0, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 2, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_APPEND, 0, 30, 5, 3, 0, 0, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 3, 0));
        // hits inside, at the view corner, and wrapping past 16 bits
        dir_tab.push_back(stim_row(vsc_pkg::ACT_HIT, 0, 0, 0, 0, 0, 0, 3, 2,
                                   0, vsc_pkg::KIND_HIT, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_HIT, 0, 0, 0, 0, 0, 0, 79, 23,
                                   0, vsc_pkg::KIND_HIT, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_HIT, 0, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF,
                                   0, vsc_pkg::KIND_HIT, 0, 0));
        // zero row scroll, and a downward one that clamps to nothing
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 0, 1, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 3, 0, 0, 0,
                                   1, vsc_pkg::KIND_SUMMARY, 0, 0));
        // real row scrolls: up, down, down clamped, up by the maximum
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 10, 1, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 4, 0, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        // column scroll by zero still clears the screen
        dir_tab.push_back(stim_row(vsc_pkg::ACT_COLS, 0, 0, 0, 0, 0, 1, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_COLS, 0, 0, 0, 0, 75, 1, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_COLS, 0, 0, 0, 0, 16'hFFFF, 0, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_ROWS, 0, 0, 0, 0, 16'hFFFF, 1, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(ACT_SPARE_MID, 0, 0, 0, 0, 0, 0, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        // clear, then hit and column scroll on the emptied table
        dir_tab.push_back(stim_row(vsc_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_HIT, 0, 0, 0, 0, 0, 0, 1, 1,
                                   0, vsc_pkg::KIND_HIT, 0, 0));
        dir_tab.push_back(stim_row(vsc_pkg::ACT_COLS, 0, 0, 0, 0, 9, 1, 0, 0,
                                   0, vsc_pkg::KIND_SUMMARY, 0, 0));

        foreach (dir_tab[i]) begin
            typed_res = {dir_tab[i].kind, dir_tab[i].idx, dir_tab[i].fnd, 48'd0, 3'b001};
            send_item(dir_tab[i].item, dir_tab[i].typed, typed_res);
        end
        i_in_valid <= 1'b0;

        // Random phases: view size and idling change only with the block drained.
        // Each phase opens with a clear and a run of appends, full tables in
        // phases 0 and 2 so that dropped appends show up.
        for (ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    set_view(vsc_pkg::VIEW_WIDTH_RST, vsc_pkg::VIEW_HEIGHT_RST);
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    set_view(16'd0, 16'd0);
                    idle_pct  = 51;
                    stall_pct = 0;
                end
                2: begin
                    set_view(16'hFFFF, 16'hFFFF);
                    idle_pct  = 0;
                    stall_pct = 51;
                end
                default: begin
                    set_view(16'd1 + (rand16() % 16'd200), 16'd1 + (rand16() % 16'd60));
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase

            typed_res = '0;
            send_item(stim_row(vsc_pkg::ACT_CLEAR, rand16(), rand16(), rand16(), rand16(),
                               rand16(), 0, rand16(), rand16(),
                               0, vsc_pkg::KIND_SUMMARY, 0, 0).item,
                      1'b0, typed_res);
            burst = (ph % 2 == 0) ? NSHAPES + 4 : $urandom_range(4, 20);
            for (n = 0; n < burst; n++)
                send_item(random_item(1'b1), 1'b0, typed_res);
            for (n = 0; n < 40; n++)
                send_item(random_item(1'b0), 1'b0, typed_res);
            i_in_valid <= 1'b0;
        end

        drain();
        $display("%0d commands sent, %0d results checked: %0d redraws, %0d hits, %0d drops",
                 items_sent, results_seen, redraws_owed, hits_owed, drops_owed);
        $display("views 80x24, 0x0, max and random; idling off, sender, receiver, both");
        if (errors == 0) begin
            $display("viewport_scroll_culling: match");
        end else begin
            $display("viewport_scroll_culling: mismatch");
        end
        $finish;
    end

endmodule
